// File: design/ipv4rt_pkg.sv
// ============================================================================
// ipv4rt_pkg
// Shared types, codes and helpers for the IPv4 route table.
// ============================================================================
package ipv4rt_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_FLUSH  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_ADDED    = 3'd3,
        ST_REJECTED = 3'd4,
        ST_FULL     = 3'd5,
        ST_REMOVED  = 3'd6,
        ST_GONE     = 3'd7
    } t_status;

    // one table row as held in the memory
    typedef struct packed {
        logic        valid;
        logic [31:0] dst;
        logic [31:0] mask;
        logic [31:0] gw;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture a beat from the request channel
        logic clr;        // write an empty row at the sweep counter
        logic scan;       // read/evaluate rows
        logic fin_flush;  // flush sweep complete, post result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;   // result register still holds a beat
        logic in_reject;  // incoming add is impossible
        logic in_flush;   // incoming beat is a flush
        logic clr_last;   // sweep counter on final row
        logic stop;       // identical route found, scan ends early
        logic last;       // final row being evaluated
    } t_dp_stat;

    function automatic logic [31:0] class_mask(input logic [1:0] cls);
        logic [31:0] m;
        case (cls)
            2'b10:   m = 32'hffff_0000;
            2'b11:   m = 32'hffff_ff00;
            default: m = 32'hff00_0000;
        endcase
        return m;
    endfunction

endpackage

// File: design/ipv4rt_if.sv
// ============================================================================
// ipv4rt_if
// Request and response channels of the IPv4 route table.
// ============================================================================
interface ipv4rt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] address;
    logic [31:0] netmask;
    logic        use_class_mask;
    logic [31:0] new_gateway;

    modport source (output valid, command, address, netmask, use_class_mask,
                    new_gateway, input ready);
    modport sink   (input valid, command, address, netmask, use_class_mask,
                    new_gateway, output ready);
endinterface

interface ipv4rt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_hop;
    logic [2:0]  status;

    modport source (output valid, next_hop, status, input ready);
    modport sink   (input valid, next_hop, status, output ready);
endinterface

// File: design/ipv4rt_ctrl.sv
// ============================================================================
// ipv4rt_ctrl
// Sequencer: reset clearing sweep, request accept, scan and flush.
// ============================================================================
module ipv4rt_ctrl import ipv4rt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE) && !i_stat.out_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_in_ready && i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.in_flush)       n_state = S_FLUSH;
                    else if (!i_stat.in_reject) n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.stop || i_stat.last) n_state = S_IDLE;
            end
            S_FLUSH: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    o_cmd.fin_flush = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

endmodule

// File: design/ipv4rt_datapath.sv
// ============================================================================
// ipv4rt_datapath
// Route memory, sweep counter, match/priority logic and result register.
// ============================================================================
module ipv4rt_datapath import ipv4rt_pkg::*; #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    output t_dp_stat      o_stat,
    input  logic [1:0]    i_command,
    input  logic [31:0]   i_address,
    input  logic [31:0]   i_netmask,
    input  logic          i_use_class_mask,
    input  logic [31:0]   i_new_gateway,
    ipv4rt_out_if.source  o_rsp
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_entry r_mem [TABLE_ENTRIES];

    t_cmd          r_cmd;
    logic [31:0]   r_addr, r_mask, r_gw;
    logic [CW-1:0] r_cnt;
    t_entry        r_rd;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_vld;
    logic          r_found, n_found;
    logic [31:0]   r_best_mask, n_best_mask, r_best_gw, n_best_gw;
    logic          r_slot_ok, n_slot_ok;
    logic [IW-1:0] r_slot, n_slot;
    logic          r_out_valid;
    logic [31:0]   r_hop, n_hop;
    t_status       r_status, n_status;

    logic          issue, ident, lk_take, free_now, hit_act, end_act, fin;
    logic [31:0]   in_mask;
    t_cmd          in_cmd;
    logic          we;
    logic [IW-1:0] waddr;
    t_entry        wdata;

    assign in_cmd  = t_cmd'(i_command);
    assign in_mask = i_use_class_mask ? class_mask(i_address[31:30]) : i_netmask;

    assign issue = i_cmd.scan && (r_cnt != CW'(TABLE_ENTRIES));
    assign ident = r_rd.valid && (r_rd.dst == r_addr) && (r_rd.mask == r_mask);

    assign o_stat.out_busy  = r_out_valid;
    assign o_stat.in_reject = (in_cmd == CMD_ADD) && ((i_address & in_mask) != i_address);
    assign o_stat.in_flush  = (in_cmd == CMD_FLUSH);
    assign o_stat.clr_last  = (r_cnt == CW'(TABLE_ENTRIES - 1));
    assign o_stat.stop      = r_rd_vld && ident &&
                              ((r_cmd == CMD_ADD) || (r_cmd == CMD_REMOVE));
    assign o_stat.last      = r_rd_vld && (r_rd_idx == IW'(TABLE_ENTRIES - 1));

    assign hit_act = i_cmd.scan && o_stat.stop;
    assign end_act = i_cmd.scan && o_stat.last && !o_stat.stop;

    // best match so far, including the row now on the read port
    assign lk_take = r_rd_vld && r_rd.valid && ((r_addr & r_rd.mask) == r_rd.dst) &&
                     (!r_found || (r_rd.mask > r_best_mask));
    assign n_found     = r_found | lk_take;
    assign n_best_mask = lk_take ? r_rd.mask : r_best_mask;
    assign n_best_gw   = lk_take ? r_rd.gw   : r_best_gw;

    // highest free row seen so far
    assign free_now  = r_rd_vld && !r_rd.valid;
    assign n_slot_ok = r_slot_ok | free_now;
    assign n_slot    = free_now ? r_rd_idx : r_slot;

    always_comb begin
        fin      = 1'b0;
        n_hop    = '0;
        n_status = ST_GONE;
        we       = 1'b0;
        waddr    = r_cnt[IW-1:0];
        wdata    = '0;
        if (i_cmd.clr) we = 1'b1;
        if (i_cmd.load && o_stat.in_reject) begin
            fin      = 1'b1;
            n_status = ST_REJECTED;
        end
        if (i_cmd.fin_flush) fin = 1'b1;
        if (hit_act) begin
            fin   = 1'b1;
            we    = 1'b1;
            waddr = r_rd_idx;
            wdata = r_rd;
            if (r_cmd == CMD_ADD) begin
                wdata.gw = r_gw;
                n_status = ST_UPDATED;
            end else begin
                wdata.valid = 1'b0;
                n_status    = ST_REMOVED;
            end
        end
        if (end_act) begin
            fin = 1'b1;
            case (r_cmd)
                CMD_LOOKUP: begin
                    n_hop    = n_found ? n_best_gw : r_addr;
                    n_status = n_found ? ST_HIT : ST_MISS;
                end
                CMD_ADD: begin
                    if (n_slot_ok) begin
                        we       = 1'b1;
                        waddr    = n_slot;
                        wdata    = '{valid: 1'b1, dst: r_addr, mask: r_mask, gw: r_gw};
                        n_status = ST_ADDED;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                default: n_status = ST_GONE;
            endcase
        end
    end

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (issue) begin
            r_rd     <= r_mem[r_cnt[IW-1:0]];
            r_rd_idx <= r_cnt[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= in_cmd;
            r_addr <= i_address;
            r_mask <= (in_cmd == CMD_ADD) ? in_mask : i_netmask;
            r_gw   <= i_new_gateway;
        end
        if (i_cmd.scan) begin
            r_best_mask <= n_best_mask;
            r_best_gw   <= n_best_gw;
            r_slot      <= n_slot;
        end
        if (fin) begin
            r_hop    <= n_hop;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_slot_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt     <= '0;
                r_rd_vld  <= 1'b0;
                r_found   <= 1'b0;
                r_slot_ok <= 1'b0;
            end else begin
                if (i_cmd.clr || issue) r_cnt <= r_cnt + CW'(1);
                r_rd_vld <= issue;
                if (i_cmd.scan) begin
                    r_found   <= n_found;
                    r_slot_ok <= n_slot_ok;
                end
            end
            if (fin)              r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.next_hop = r_hop;
    assign o_rsp.status   = r_status;

endmodule

// File: design/ipv4_route_table.sv
// ============================================================================
// ipv4_route_table
// IPv4 longest-mask route table: lookup, add, remove and flush over a
// scanned route memory.
// ============================================================================
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    command, address, netmask, use_class_mask,
//                                new_gateway
//  o_rsp     out  valid/ready    next_hop, status
//
//  Lookup, add and remove read one row a cycle from the single memory read
//  port, and the result register loads once the last row has been read;
//  an add or remove that hits ends its scan early. A rejected add is
//  answered without a scan; flush is a clearing sweep over every row.
//  After reset the same sweep empties the table before the first request
//  beat is taken.
//  A new request is taken only when idle and the result register is empty;
//  a stalled response simply holds the register.
// ============================================================================
module ipv4_route_table import ipv4rt_pkg::*; #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ipv4rt_in_if.sink    i_req,
    ipv4rt_out_if.source o_rsp
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;

    assign i_req.ready = in_ready;

    // sequencer
    ipv4rt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (dp_stat),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    // route memory and match logic
    ipv4rt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_command        (i_req.command),
        .i_address        (i_req.address),
        .i_netmask        (i_req.netmask),
        .i_use_class_mask (i_req.use_class_mask),
        .i_new_gateway    (i_req.new_gateway),
        .o_rsp            (o_rsp)
    );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the IPv4 route table: a directed opening and
// random route traffic, with every response checked against a predicted
// copy of the table.
// ============================================================================
module tb_top;
    import ipv4rt_pkg::*;

    localparam int ENTRIES   = 256;
    localparam int MAX_CYC   = 2_000_000;
    localparam int N_RANDOM  = 470;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] addr;
        logic [31:0] nmask;
        logic        use_cls;
        logic [31:0] gw;
    } t_req;

    typedef struct {
        logic [31:0] hop;
        t_status     st;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ipv4rt_in_if  req_if ();
    ipv4rt_out_if rsp_if ();

    ipv4_route_table #(.TABLE_ENTRIES(ENTRIES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predicted route table
    logic        rt_valid [ENTRIES];
    logic [31:0] rt_dst   [ENTRIES];
    logic [31:0] rt_mask  [ENTRIES];
    logic [31:0] rt_gw    [ENTRIES];

    t_req  pending_reqs [$];
    t_rsp  expected_rsps [$];
    int    mismatches = 0;
    int    cycles = 0;
    bit    stim_done = 1'b0;
    int    status_seen [8];

    // seed list of route prefixes, so lookups and removes often hit
    logic [31:0] known_dst [$];
    logic [31:0] known_mask [$];

    function automatic t_rsp route_predict(input t_req r);
        t_rsp        o;
        logic        found;
        logic [31:0] best_m, best_g, m;
        int          slot;
        o.hop = '0;
        case (r.cmd)
            CMD_LOOKUP: begin
                found = 1'b0; best_m = '0; best_g = '0;
                for (int i = 0; i < ENTRIES; i++)
                    if (rt_valid[i] && (r.addr & rt_mask[i]) == rt_dst[i] &&
                        (!found || rt_mask[i] > best_m)) begin
                        found = 1'b1; best_m = rt_mask[i]; best_g = rt_gw[i];
                    end
                o.hop = found ? best_g : r.addr;
                o.st  = found ? ST_HIT : ST_MISS;
            end
            CMD_ADD: begin
                // classful mask from the top two address bits
                case (r.addr[31:30])
                    2'b10:   m = 32'hffff_0000;
                    2'b11:   m = 32'hffff_ff00;
                    default: m = 32'hff00_0000;
                endcase
                if (!r.use_cls) m = r.nmask;
                slot = -1;
                o.st = ST_FULL;
                if ((r.addr & m) != r.addr) o.st = ST_REJECTED;
                else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!rt_valid[i]) slot = i;
                        else if (rt_dst[i] == r.addr && rt_mask[i] == m) begin
                            rt_gw[i] = r.gw; o.st = ST_UPDATED; break;
                        end
                    end
                    if (o.st == ST_FULL && slot >= 0) begin
                        rt_valid[slot] = 1'b1; rt_dst[slot] = r.addr;
                        rt_mask[slot] = m; rt_gw[slot] = r.gw; o.st = ST_ADDED;
                    end
                end
            end
            CMD_REMOVE: begin
                o.st = ST_GONE;
                for (int i = 0; i < ENTRIES; i++)
                    if (rt_valid[i] && rt_dst[i] == r.addr && rt_mask[i] == r.nmask) begin
                        rt_valid[i] = 1'b0; o.st = ST_REMOVED; break;
                    end
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++) rt_valid[i] = 1'b0;
                o.st = ST_GONE;
            end
        endcase
        return o;
    endfunction

    function automatic t_req mk_req(input t_cmd c, input logic [31:0] a,
                                    input logic [31:0] m, input logic u,
                                    input logic [31:0] g);
        t_req r;
        r.cmd = c; r.addr = a; r.nmask = m; r.use_cls = u; r.gw = g;
        return r;
    endfunction

    function automatic logic [31:0] rand_mask();
        int len;
        len = $urandom_range(0, 32);
        return (len == 0) ? 32'h0 : ~32'h0 << (32 - len);
    endfunction

    // random route traffic: mostly well-formed adds and lookups that hit
    task automatic fill_random();
        t_req        r;
        logic [31:0] m, a;
        int          k, pick;
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            r = mk_req(CMD_LOOKUP, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom);
            if (pick < 35) begin
                r.cmd = CMD_ADD;
                if ($urandom_range(0, 3) == 0) begin
                    r.use_cls = 1'b1;
                    r.addr = $urandom;
                    if ($urandom_range(0, 1)) r.addr[7:0] = 8'h0;
                    if ($urandom_range(0, 1)) r.addr[15:0] = 16'h0;
                    if (r.addr[31:30] != 2'b11 || $urandom_range(0, 1))
                        r.addr[23:0] = 24'h0;
                end else if ($urandom_range(0, 9) == 0) begin
                    r.use_cls = 1'b0;  // likely impossible add
                end else begin
                    r.use_cls = 1'b0;
                    m = rand_mask();
                    if (known_dst.size() > 0 && $urandom_range(0, 2) == 0) begin
                        k = $urandom_range(0, known_dst.size() - 1);
                        r.addr = known_dst[k]; m = known_mask[k];
                    end else r.addr = $urandom & m;
                    r.nmask = m;
                    known_dst.push_back(r.addr); known_mask.push_back(m);
                end
            end else if (pick < 80) begin
                if (known_dst.size() > 0 && $urandom_range(0, 3) != 0) begin
                    k = $urandom_range(0, known_dst.size() - 1);
                    r.addr = known_dst[k] | ($urandom & ~known_mask[k]);
                end
            end else if (pick < 97) begin
                r.cmd = CMD_REMOVE;
                if (known_dst.size() > 0 && $urandom_range(0, 2) != 0) begin
                    k = $urandom_range(0, known_dst.size() - 1);
                    r.addr = known_dst[k]; r.nmask = known_mask[k];
                end
            end else begin
                r.cmd = CMD_FLUSH;
            end
            pending_reqs.push_back(r);
        end
    endtask

    initial begin
        // directed: field extremes, classes, special cases
        pending_reqs.push_back(mk_req(CMD_LOOKUP, 32'hffff_ffff, 32'h0, 1'b0, 32'h0));
        pending_reqs.push_back(mk_req(CMD_REMOVE, 32'h0, 32'h0, 1'b1, 32'h0));
        pending_reqs.push_back(mk_req(CMD_ADD, 32'h0, 32'h0, 1'b0, 32'hffff_ffff));
        pending_reqs.push_back(mk_req(CMD_LOOKUP, 32'h1234_5678, 32'h0, 1'b0, 32'h0));
        pending_reqs.push_back(mk_req(CMD_ADD, 32'h0a00_0000, 32'hffff_ffff, 1'b1, 32'h0a00_0001));
        pending_reqs.push_back(mk_req(CMD_ADD, 32'h4100_0000, 32'h0, 1'b1, 32'h4100_0001));
        pending_reqs.push_back(mk_req(CMD_ADD, 32'hac10_0000, 32'h0, 1'b1, 32'hac10_0001));
        pending_reqs.push_back(mk_req(CMD_ADD, 32'hc0a8_0100, 32'h0, 1'b1, 32'hc0a8_0101));
        pending_reqs.push_back(mk_req(CMD_ADD, 32'hc0a8_0101, 32'h0, 1'b1, 32'h1));
        pending_reqs.push_back(mk_req(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h5555_aaaa));
        pending_reqs.push_back(mk_req(CMD_ADD, 32'h0a00_0000, 32'hff00_0000, 1'b0, 32'h0a0a_0a0a));
        pending_reqs.push_back(mk_req(CMD_LOOKUP, 32'hc0a8_0105, 32'h0, 1'b0, 32'h0));
        pending_reqs.push_back(mk_req(CMD_LOOKUP, 32'hffff_ffff, 32'h0, 1'b0, 32'h0));
        pending_reqs.push_back(mk_req(CMD_LOOKUP, 32'h0a01_0203, 32'h0, 1'b0, 32'h0));
        pending_reqs.push_back(mk_req(CMD_REMOVE, 32'hc0a8_0100, 32'hffff_0000, 1'b1, 32'h0));
        pending_reqs.push_back(mk_req(CMD_REMOVE, 32'hc0a8_0100, 32'hffff_ff00, 1'b0, 32'h0));
        pending_reqs.push_back(mk_req(CMD_FLUSH, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_ffff));
        pending_reqs.push_back(mk_req(CMD_LOOKUP, 32'hc0a8_0105, 32'h0, 1'b0, 32'h0));
        // fill the table to overflow with distinct host routes
        for (int i = 0; i < ENTRIES + 2; i++)
            pending_reqs.push_back(mk_req(CMD_ADD, 32'h0b00_0000 + i, 32'hffff_ffff,
                                          1'b0, $urandom));
        pending_reqs.push_back(mk_req(CMD_ADD, 32'h0b00_0003, 32'hffff_ffff, 1'b0, 32'h77));
        pending_reqs.push_back(mk_req(CMD_LOOKUP, 32'h0b00_0003, 32'h0, 1'b0, 32'h0));
        pending_reqs.push_back(mk_req(CMD_FLUSH, 32'h0, 32'h0, 1'b0, 32'h0));
        fill_random();
    end

    // driver: bursts of beats with random gaps between them
    int   burst_left = 0;
    int   gap_left = 0;
    t_req cur_req;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) expected_rsps.push_back(route_predict(cur_req));
            if (gap_left > 0 || pending_reqs.size() == 0) begin
                req_if.valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
                if (pending_reqs.size() == 0 && !req_if.valid) stim_done <= 1'b1;
            end else begin
                cur_req = pending_reqs.pop_front();
                req_if.valid          <= 1'b1;
                req_if.command        <= cur_req.cmd;
                req_if.address        <= cur_req.addr;
                req_if.netmask        <= cur_req.nmask;
                req_if.use_class_mask <= cur_req.use_cls;
                req_if.new_gateway    <= cur_req.gw;
                if (burst_left > 0) burst_left <= burst_left - 1;
                else begin
                    burst_left <= $urandom_range(0, 6);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
                end
            end
        end
    end

    // receiver stall pattern: stretches of free flow and random stalls
    logic [5:0] stall_phase = '0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        if (stall_phase[5]) rsp_if.ready <= 1'b1;
        else rsp_if.ready <= ($urandom_range(0, 3) != 0);
    end

    // monitor: compare each response beat with the oldest prediction
    always @(posedge i_clk) begin
        t_rsp e;
        cycles <= cycles + 1;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected response beat: hop %h status %0d",
                             rsp_if.next_hop, rsp_if.status);
            end else begin
                e = expected_rsps.pop_front();
                status_seen[e.st] <= status_seen[e.st] + 1;
                if (rsp_if.next_hop !== e.hop || rsp_if.status !== e.st) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: hop %h/%h status %0d/%0d (exp/act)",
                                 e.hop, rsp_if.next_hop, e.st, rsp_if.status);
                end
            end
        end
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.command = CMD_LOOKUP;
        req_if.address = '0;
        req_if.netmask = '0;
        req_if.use_class_mask = 1'b0;
        req_if.new_gateway = '0;
        rsp_if.ready = 1'b0;
        for (int i = 0; i < ENTRIES; i++) rt_valid[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            begin
                wait (stim_done && expected_rsps.size() == 0);
                repeat (ENTRIES + 20) @(posedge i_clk);
                $display("checked %0d response beats (%0d random requests);",
                         status_seen.sum(), N_RANDOM);
                $display("statuses hit/miss/upd/add/rej/full/rem/gone:");
                $display("  %0d %0d %0d %0d %0d %0d %0d %0d", status_seen[0],
                         status_seen[1], status_seen[2], status_seen[3], status_seen[4],
                         status_seen[5], status_seen[6], status_seen[7]);
                if (mismatches == 0 && expected_rsps.size() == 0)
                    $display("PASS ipv4_route_table");
                else
                    $display("FAIL ipv4_route_table");
                $finish;
            end
            begin
                wait (cycles >= MAX_CYC);
                $display("timeout after %0d cycles", cycles);
                $display("FAIL ipv4_route_table");
                $finish;
            end
        join
    end

endmodule
